[src/apafg_pkg.sv]
`default_nettype none
package apafg_pkg;

  // Input beat kinds carried on in_tuser
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Register indexes
  localparam int unsigned REG_PIXEL_COUNT = 0;

  localparam int unsigned PIXELS_DEF   = 256;
  localparam int unsigned COUNT_W      = 9;
  localparam int unsigned COLOR_W      = 8;
  localparam int unsigned ENTRY_W      = 3 * COLOR_W;

  // Frame layout
  localparam int unsigned LEAD_BYTES   = 4;
  localparam int unsigned TAIL_BYTES   = 5;
  localparam int unsigned TAIL_SHIFT   = 4;          // one extra tail byte per 16 pixels
  localparam logic [7:0]  HDR_BYTE     = 8'hE0 | 8'd31;
  localparam logic [7:0]  END_BYTE     = 8'hFF;
  localparam logic [7:0]  ZERO_BYTE    = 8'h00;

  // Byte slot inside one pixel group
  localparam logic [1:0]  SLOT_HDR     = 2'd0;
  localparam logic [1:0]  SLOT_BLUE    = 2'd1;
  localparam logic [1:0]  SLOT_GREEN   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage
`default_nettype wire

[src/apafg_store.sv]
`default_nettype none
module apafg_store
  import apafg_pkg::*;
#(
  parameter int unsigned DEPTH = PIXELS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [ENTRY_W-1:0] wdata,
  input  wire logic               re,
  input  wire logic [AW-1:0]      raddr,
  output logic      [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/apa102_frame_generator_top.sv]
`default_nettype none
// APA102 LED strip frame generator. Write pixels into the store with
// write-pixel beats (in_tuser = 0), set cfg pixel_count, then send a start
// beat (in_tuser = 1) and feed one tick beat (in_tuser = 2) per strip clock
// pulse; each tick during a frame returns one serial bit, MSB first, on
// out_tdata[0]. A frame is four 0x00 bytes, a 0xFF/blue/green/red group per
// pixel, 0xFF, then 5 + count/16 zero bytes; out_tuser marks bit zero of each
// byte and out_tlast the final bit of the frame. The count is latched and
// saturated to PIXELS at start; starts during a frame, ticks while idle and
// kind 3 produce nothing. Write, start and idle tick beats never hold the
// input. A tick during a frame holds it: the pixel store is a single
// synchronous RAM read on the accept edge, and the bit is formed from the
// registered read data in the emit state once the output is free. Pixel
// writes stay legal during a frame and are seen by the next tick. The store
// has no reset; an entry never written since reset sends unspecified data. A
// finished bit waits in the output register while the next beat is taken.
module apa102_frame_generator_top
  import apafg_pkg::*;
#(
  parameter int unsigned PIXELS = PIXELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // pixel_index, red, green, blue
  input  wire logic [1:0]  in_tuser,   // command
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // data_bit, zero fill
  output logic             out_tuser,  // byte_last
  output logic             out_tlast,  // frame_last
  // Configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned NW = $clog2(PIXELS + 1);
  localparam int unsigned BW = $clog2(LEAD_BYTES + TAIL_BYTES + 1 + 4 * PIXELS
                                      + PIXELS / 16);
  localparam logic [NW-1:0] PIX_MAX = NW'(PIXELS);

  // Configuration register
  logic [COUNT_W-1:0] count_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                    & (32'(cfg_paddr[2]) == REG_PIXEL_COUNT);
  assign cfg_prdata = (32'(cfg_paddr[2]) == REG_PIXEL_COUNT) ? 32'(count_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr) begin
      count_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  // Input beat decode
  logic [1:0]         cmd;
  logic [7:0]         idx;
  logic [ENTRY_W-1:0] entry_in;
  logic               acc;

  assign cmd      = in_tuser;
  assign idx      = in_tdata[7:0];
  // Store entry: red high, blue low
  assign entry_in = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};

  // Frame control state
  state_t        state_r, state_nxt;
  logic          busy_r, busy_nxt;
  logic [BW-1:0] pos_r, pos_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [BW-1:0] pix_end_r, pix_end_nxt;     // byte index of the 0xFF end byte
  logic [BW-1:0] last_pos_r, last_pos_nxt;   // byte index of the last frame byte

  logic          out_valid_r, out_valid_nxt;
  logic          out_bit_r, out_bit_nxt;
  logic          out_blast_r, out_blast_nxt;
  logic          out_flast_r, out_flast_nxt;

  logic [NW-1:0]      n_sat;
  logic               st_we, st_re;
  logic [AW-1:0]      st_raddr;
  logic [BW-3:0]      px_grp;
  logic [ENTRY_W-1:0] st_rdata;
  logic [7:0]         cur_byte;
  logic               out_free;
  logic               is_blast, is_flast;

  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid & in_tready;

  assign n_sat = (32'(count_r) > PIXELS) ? PIX_MAX : NW'(count_r);

  // Pixel group of the current byte: (pos - 4) / 4
  assign px_grp   = pos_r[BW-1:2] - 1'b1;
  assign st_raddr = AW'(px_grp);
  assign st_we    = acc & (cmd == CMD_WRITE) & (32'(idx) < PIXELS);
  assign st_re    = acc & (cmd == CMD_TICK) & busy_r;

  apafg_store #(
    .DEPTH (PIXELS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (AW'(idx)),
    .wdata (entry_in),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Byte on the wire at the current position
  always_comb begin
    cur_byte = ZERO_BYTE;
    if (32'(pos_r) < LEAD_BYTES) begin
      cur_byte = ZERO_BYTE;
    end else if (pos_r < pix_end_r) begin
      case (pos_r[1:0])
        SLOT_HDR:   cur_byte = HDR_BYTE;
        SLOT_BLUE:  cur_byte = st_rdata[7:0];
        SLOT_GREEN: cur_byte = st_rdata[15:8];
        default:    cur_byte = st_rdata[23:16];
      endcase
    end else if (pos_r == pix_end_r) begin
      cur_byte = END_BYTE;
    end
  end

  assign out_free = ~out_valid_r | out_tready;
  assign is_blast = (bit_r == 3'd7);
  assign is_flast = is_blast & (pos_r == last_pos_r);

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    pos_nxt       = pos_r;
    bit_nxt       = bit_r;
    pix_end_nxt   = pix_end_r;
    last_pos_nxt  = last_pos_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_bit_nxt   = out_bit_r;
    out_blast_nxt = out_blast_r;
    out_flast_nxt = out_flast_r;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (cmd == CMD_START && !busy_r) begin
            busy_nxt     = 1'b1;
            pos_nxt      = '0;
            bit_nxt      = '0;
            pix_end_nxt  = BW'(LEAD_BYTES) + BW'({n_sat, 2'b00});
            last_pos_nxt = BW'(LEAD_BYTES + TAIL_BYTES) + BW'({n_sat, 2'b00})
                         + BW'(n_sat >> TAIL_SHIFT);
          end else if (cmd == CMD_TICK && busy_r) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // Hold until the output register can take the bit
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = cur_byte[3'd7 - bit_r];
          out_blast_nxt = is_blast;
          out_flast_nxt = is_flast;
          state_nxt     = ST_IDLE;
          if (is_flast) begin
            busy_nxt = 1'b0;
            pos_nxt  = '0;
            bit_nxt  = '0;
          end else if (is_blast) begin
            bit_nxt = '0;
            pos_nxt = pos_r + 1'b1;
          end else begin
            bit_nxt = bit_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      pos_r       <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      pos_r       <= pos_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_end_r   <= pix_end_nxt;
    last_pos_r  <= last_pos_nxt;
    out_bit_r   <= out_bit_nxt;
    out_blast_r <= out_blast_nxt;
    out_flast_r <= out_flast_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};
  assign out_tuser  = out_blast_r;
  assign out_tlast  = out_flast_r;

endmodule
`default_nettype wire

[src/apafg_checker.sv]
`default_nettype none
module apafg_checker
  import apafg_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [1:0] in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser,
  input wire logic       out_tlast
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Only ticks occupy the generator past their accept cycle
  a_non_tick_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != CMD_TICK |=> in_tready)
    else $error("non-tick beat stalled the input");

  // The last bit of a frame is also the last bit of a byte
  a_flast_blast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("frame end off a byte boundary");

  // Fill bits of the result stay zero
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0)
    else $error("result fill bits set");

endmodule

bind apa102_frame_generator_top apafg_checker u_apafg_checker (.*);
`default_nettype wire
